/* design/chained_hash_index_macros.svh */
// Assertion macros shared by the chained hash index modules.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef CHAINED_HASH_INDEX_MACROS_SVH
`define CHAINED_HASH_INDEX_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CHI_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define CHI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/chi_pkg.sv */
// Package for the chained hash index: default sizes, field widths, codes and
// the command and status structs between controller and datapath. No dependencies.
package chi_pkg;

  localparam int unsigned PRIMARY_BUCKETS_DEF  = 4096;
  localparam int unsigned OVERFLOW_BUCKETS_DEF = 1024;
  localparam int unsigned OFFSET_BITS_DEF      = 32;

  localparam int unsigned KEY_W    = 64;
  localparam int unsigned OFF_IN_W = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned DIGIT_W  = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_NEXT   = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_HIT       = 2'd1,
    ST_NO_MORE   = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RD_CURSOR = 2'd0,
    RD_SLOT   = 2'd1,
    RD_LINK   = 2'd2
  } rd_sel_t;

  typedef enum logic [2:0] {
    WR_NONE  = 3'd0,
    WR_CLEAR = 3'd1,
    WR_HEAD  = 3'd2,
    WR_ALLOC = 3'd3,
    WR_LINK  = 3'd4
  } wr_sel_t;

  typedef struct packed {
    logic    latch;
    logic    mod_start;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    load_slot;
    logic    set_search;
    logic    step_cur;
    logic    scan_update;
    logic    bump_free;
    logic    res_load;
    status_t res_status;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic mod_done;
    logic key_empty;
    logic key_match;
    logic link_nz;
    logic pool_full;
    logic search_active;
    logic clr_last;
  } dp_status_t;

endpackage

/* design/chi_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies beyond chi_pkg for default sizes.
module chi_ram #(
  parameter int unsigned WIDTH = chi_pkg::KEY_W,
  parameter int unsigned DEPTH = chi_pkg::PRIMARY_BUCKETS_DEF + chi_pkg::OVERFLOW_BUCKETS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/chi_mod.sv */
// Primary bucket index unit: key modulo the primary bucket count.
// A mask for a power-of-two count, otherwise one key byte per cycle. Uses chi_pkg.
module chi_mod #(
  parameter int unsigned PRIMARY_BUCKETS = chi_pkg::PRIMARY_BUCKETS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [chi_pkg::KEY_W-1:0]          key,
  output logic                               done,
  output logic [$clog2(PRIMARY_BUCKETS)-1:0] slot
);

  localparam int unsigned SLOT_W  = $clog2(PRIMARY_BUCKETS);
  localparam bit          IS_POW2 = (PRIMARY_BUCKETS & (PRIMARY_BUCKETS - 1)) == 0;

  generate
    if (IS_POW2) begin : g_mask
      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else begin
          done <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          slot <= key[SLOT_W-1:0];
        end
      end
    end else begin : g_digit
      localparam int unsigned DIGITS = chi_pkg::KEY_W / chi_pkg::DIGIT_W;
      localparam int unsigned CNT_W  = $clog2(DIGITS);
      localparam int unsigned T_W    = SLOT_W + chi_pkg::DIGIT_W;

      logic                      run;
      logic [CNT_W-1:0]          cnt;
      logic [chi_pkg::KEY_W-1:0] sh;
      logic [T_W-1:0]            t;

      // Shift in the next byte and reduce below the bucket count again.
      always_comb begin
        t = {slot, sh[chi_pkg::KEY_W-1 -: chi_pkg::DIGIT_W]};
        for (int k = chi_pkg::DIGIT_W - 1; k >= 0; k--) begin
          if (t >= (T_W'(PRIMARY_BUCKETS) << k)) begin
            t = t - (T_W'(PRIMARY_BUCKETS) << k);
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          run  <= 1'b0;
          done <= 1'b0;
          cnt  <= '0;
        end else begin
          done <= 1'b0;
          if (start) begin
            run <= 1'b1;
            cnt <= '0;
          end else if (run) begin
            cnt <= cnt + CNT_W'(1);
            if (cnt == CNT_W'(DIGITS - 1)) begin
              run  <= 1'b0;
              done <= 1'b1;
            end
          end
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          slot <= '0;
          sh   <= key;
        end else if (run) begin
          slot <= t[SLOT_W-1:0];
          sh   <= sh << chi_pkg::DIGIT_W;
        end
      end
    end
  endgenerate

endmodule

/* design/chi_datapath.sv */
// Datapath of the chained hash index: bucket memories, search and pool registers,
// the index unit and the result registers. Uses chi_pkg, chi_ram, chi_mod, the macros.
`include "chained_hash_index_macros.svh"

module chi_datapath #(
  parameter int unsigned PRIMARY_BUCKETS  = chi_pkg::PRIMARY_BUCKETS_DEF,
  parameter int unsigned OVERFLOW_BUCKETS = chi_pkg::OVERFLOW_BUCKETS_DEF,
  parameter int unsigned OFFSET_BITS      = chi_pkg::OFFSET_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [chi_pkg::KEY_W-1:0]    hash_key,
  input  logic [chi_pkg::OFF_IN_W-1:0] row_offset,
  input  chi_pkg::dp_cmd_t             cmd,
  output chi_pkg::dp_status_t          st,
  output logic [chi_pkg::STATUS_W-1:0] status,
  output logic [chi_pkg::OFF_IN_W-1:0] found_offset
);

  localparam int unsigned TOTAL  = PRIMARY_BUCKETS + OVERFLOW_BUCKETS;
  localparam int unsigned LINK_W = $clog2(TOTAL);
  localparam int unsigned FREE_W = $clog2(TOTAL + 1);
  localparam int unsigned SLOT_W = $clog2(PRIMARY_BUCKETS);

  logic [chi_pkg::KEY_W-1:0]    key_eff;
  logic [chi_pkg::KEY_W-1:0]    key_r;
  logic [OFFSET_BITS-1:0]       off_r;
  logic [LINK_W-1:0]            cur;
  logic [LINK_W-1:0]            cursor;
  logic [chi_pkg::KEY_W-1:0]    search_key;
  logic                         search_active;
  logic [FREE_W-1:0]            next_free;
  logic [SLOT_W-1:0]            clr_addr;
  chi_pkg::status_t             res_status;
  logic [chi_pkg::OFF_IN_W-1:0] res_off;

  logic                         mod_done;
  logic [SLOT_W-1:0]            slot;
  logic [LINK_W-1:0]            slot_ext;

  logic [chi_pkg::KEY_W-1:0]    key_rd;
  logic [OFFSET_BITS-1:0]       off_rd;
  logic [LINK_W-1:0]            link_rd;
  logic [LINK_W-1:0]            link_val;

  logic [LINK_W-1:0]            raddr;
  logic [LINK_W-1:0]            waddr;
  logic                         key_we;
  logic                         off_we;
  logic                         link_we;
  logic [chi_pkg::KEY_W-1:0]    key_wd;
  logic [LINK_W-1:0]            link_wd;

  assign key_eff  = (hash_key == '0) ? chi_pkg::KEY_W'(1) : hash_key;
  assign slot_ext = LINK_W'(slot);
  // A link outside the table ends the chain.
  assign link_val = ({1'b0, link_rd} >= (LINK_W + 1)'(TOTAL)) ? '0 : link_rd;

  chi_mod #(
    .PRIMARY_BUCKETS(PRIMARY_BUCKETS)
  ) u_mod (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.mod_start),
    .key  (key_eff),
    .done (mod_done),
    .slot (slot)
  );

  always_comb begin
    unique case (cmd.rd_sel)
      chi_pkg::RD_CURSOR: raddr = cursor;
      chi_pkg::RD_SLOT:   raddr = slot_ext;
      chi_pkg::RD_LINK:   raddr = link_val;
      default:            raddr = cursor;
    endcase
  end

  always_comb begin
    waddr   = cur;
    key_we  = 1'b0;
    off_we  = 1'b0;
    link_we = 1'b0;
    key_wd  = key_r;
    link_wd = '0;
    unique case (cmd.wr_sel)
      chi_pkg::WR_NONE: begin
      end
      chi_pkg::WR_CLEAR: begin
        waddr   = LINK_W'(clr_addr);
        key_we  = 1'b1;
        link_we = 1'b1;
        key_wd  = '0;
      end
      chi_pkg::WR_HEAD: begin
        key_we  = 1'b1;
        off_we  = 1'b1;
        link_we = 1'b1;
      end
      chi_pkg::WR_ALLOC: begin
        waddr   = next_free[LINK_W-1:0];
        key_we  = 1'b1;
        off_we  = 1'b1;
        link_we = 1'b1;
      end
      chi_pkg::WR_LINK: begin
        link_we = 1'b1;
        link_wd = next_free[LINK_W-1:0];
      end
      default: begin
      end
    endcase
  end

  chi_ram #(
    .WIDTH(chi_pkg::KEY_W),
    .DEPTH(TOTAL)
  ) u_key_ram (
    .clk  (clk),
    .we   (key_we),
    .waddr(waddr),
    .wdata(key_wd),
    .raddr(raddr),
    .rdata(key_rd)
  );

  chi_ram #(
    .WIDTH(OFFSET_BITS),
    .DEPTH(TOTAL)
  ) u_off_ram (
    .clk  (clk),
    .we   (off_we),
    .waddr(waddr),
    .wdata(off_r),
    .raddr(raddr),
    .rdata(off_rd)
  );

  chi_ram #(
    .WIDTH(LINK_W),
    .DEPTH(TOTAL)
  ) u_link_ram (
    .clk  (clk),
    .we   (link_we),
    .waddr(waddr),
    .wdata(link_wd),
    .raddr(raddr),
    .rdata(link_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor        <= '0;
      search_key    <= '0;
      search_active <= 1'b0;
      next_free     <= FREE_W'(PRIMARY_BUCKETS);
      clr_addr      <= '0;
    end else begin
      if (cmd.wr_sel == chi_pkg::WR_CLEAR) begin
        clr_addr <= clr_addr + SLOT_W'(1);
      end
      if (cmd.set_search) begin
        search_key    <= key_r;
        cursor        <= slot_ext;
        search_active <= 1'b1;
      end else if (cmd.scan_update) begin
        search_active <= (link_val != '0);
        if (link_val != '0) begin
          cursor <= link_val;
        end
      end
      if (cmd.bump_free) begin
        next_free <= next_free + FREE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      key_r <= key_eff;
      off_r <= OFFSET_BITS'(row_offset);
    end
    if (cmd.load_slot) begin
      cur <= slot_ext;
    end else if (cmd.step_cur) begin
      cur <= link_val;
    end
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      res_off    <= (cmd.res_status == chi_pkg::ST_HIT) ? chi_pkg::OFF_IN_W'(off_rd) : '0;
    end
    if (cmd.out_load) begin
      status       <= res_status;
      found_offset <= res_off;
    end
  end

  always_comb begin
    st.mod_done      = mod_done;
    st.key_empty     = (key_rd == '0);
    st.key_match     = (key_rd == search_key);
    st.link_nz       = (link_val != '0);
    st.pool_full     = (next_free >= FREE_W'(TOTAL));
    st.search_active = search_active;
    st.clr_last      = (clr_addr == SLOT_W'(PRIMARY_BUCKETS - 1));
  end

  `CHI_ASSERT_IMPL(a_head_in_primary,
    cmd.wr_sel == chi_pkg::WR_HEAD,
    cur < LINK_W'(PRIMARY_BUCKETS),
    "head write outside primary buckets")
  `CHI_ASSERT_IMPL(a_link_to_pool,
    cmd.wr_sel == chi_pkg::WR_LINK,
    next_free >= FREE_W'(PRIMARY_BUCKETS) && next_free < FREE_W'(TOTAL),
    "link to a bucket outside the pool")

endmodule

/* design/chi_ctrl.sv */
// Controller of the chained hash index: sequences clearing, insert walks and
// lookup scans, and owns the item handshakes. Uses chi_pkg and the macros.
`include "chained_hash_index_macros.svh"

module chi_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic [chi_pkg::CMD_W-1:0] in_cmd,
  output logic                      in_stall,
  output logic                      out_valid,
  input  logic                      out_stall,
  output chi_pkg::dp_cmd_t          cmd,
  input  chi_pkg::dp_status_t       st
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_INS_HEAD,
    S_INS_WALK,
    S_INS_ALLOC,
    S_INS_LINK,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   is_lookup;
  logic   is_lookup_next;
  logic   out_valid_next;

  always_comb begin
    cmd            = '0;
    cmd.rd_sel     = chi_pkg::RD_CURSOR;
    cmd.wr_sel     = chi_pkg::WR_NONE;
    cmd.res_status = chi_pkg::ST_NO_MORE;
    state_next     = state;
    is_lookup_next = is_lookup;
    unique case (state)
      S_CLEAR: begin
        cmd.wr_sel = chi_pkg::WR_CLEAR;
        if (st.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          unique case (in_cmd)
            chi_pkg::CMD_INSERT: begin
              cmd.mod_start  = 1'b1;
              is_lookup_next = 1'b0;
              state_next     = S_HASH;
            end
            chi_pkg::CMD_LOOKUP: begin
              cmd.mod_start  = 1'b1;
              is_lookup_next = 1'b1;
              state_next     = S_HASH;
            end
            chi_pkg::CMD_NEXT: begin
              if (st.search_active) begin
                state_next = S_SCAN;
              end else begin
                cmd.res_load = 1'b1;
                state_next   = S_DONE;
              end
            end
            default: begin
              cmd.res_load = 1'b1;
              state_next   = S_DONE;
            end
          endcase
        end
      end
      S_HASH: begin
        if (st.mod_done) begin
          cmd.load_slot = 1'b1;
          cmd.rd_sel    = chi_pkg::RD_SLOT;
          if (is_lookup) begin
            cmd.set_search = 1'b1;
            state_next     = S_SCAN;
          end else begin
            state_next = S_INS_HEAD;
          end
        end
      end
      S_INS_HEAD: begin
        if (st.key_empty) begin
          cmd.wr_sel     = chi_pkg::WR_HEAD;
          cmd.res_load   = 1'b1;
          cmd.res_status = chi_pkg::ST_INSERTED;
          state_next     = S_DONE;
        end else if (st.link_nz) begin
          cmd.step_cur = 1'b1;
          cmd.rd_sel   = chi_pkg::RD_LINK;
          state_next   = S_INS_WALK;
        end else begin
          state_next = S_INS_ALLOC;
        end
      end
      S_INS_WALK: begin
        if (st.link_nz) begin
          cmd.step_cur = 1'b1;
          cmd.rd_sel   = chi_pkg::RD_LINK;
        end else begin
          state_next = S_INS_ALLOC;
        end
      end
      S_INS_ALLOC: begin
        if (st.pool_full) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = chi_pkg::ST_EXHAUSTED;
          state_next     = S_DONE;
        end else begin
          cmd.wr_sel = chi_pkg::WR_ALLOC;
          state_next = S_INS_LINK;
        end
      end
      S_INS_LINK: begin
        cmd.wr_sel     = chi_pkg::WR_LINK;
        cmd.bump_free  = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_status = chi_pkg::ST_INSERTED;
        state_next     = S_DONE;
      end
      S_SCAN: begin
        cmd.scan_update = 1'b1;
        if (st.key_match) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = chi_pkg::ST_HIT;
          state_next     = S_DONE;
        end else if (st.link_nz) begin
          cmd.rd_sel = chi_pkg::RD_LINK;
        end else begin
          cmd.res_load = 1'b1;
          state_next   = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_valid_next = (out_valid && out_stall) || cmd.out_load;
  assign in_stall       = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      is_lookup <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      is_lookup <= is_lookup_next;
      out_valid <= out_valid_next;
    end
  end

  `CHI_ASSERT_IMPL(a_alloc_has_room, cmd.wr_sel == chi_pkg::WR_ALLOC, !st.pool_full, "overflow bucket taken from a full pool")
  `CHI_ASSERT_IMPL(a_index_while_waiting, st.mod_done, state == S_HASH, "bucket index ready outside the hash wait")
  `CHI_ASSERT_NEXT(a_result_posted, cmd.out_load, out_valid && state == S_IDLE, "result not posted after load")

endmodule

/* design/chained_hash_index.sv */
// Chained hash index: a bucket table with an overflow pool and chain links,
// serving insert, lookup-first and lookup-next items one at a time.
// Top level; uses chi_pkg, chi_ctrl and chi_datapath.
//
// After reset the block clears the primary buckets (4096 by default), one per
// cycle, and holds in_stall high meanwhile. It then takes one item at a time;
// each item gives exactly one result item, and the next item is taken while a
// result waits on out_stall. Lookups, lookup-nexts and inserts into a chain
// walk the chain bucket by bucket; the bucket memories, with one read per
// cycle, set the walk rate. With a primary bucket count that is not a power of
// two, inserts and lookups use the byte-serial index unit. Key hash zero is
// stored and searched as one.
module chained_hash_index #(
  parameter int unsigned PRIMARY_BUCKETS  = chi_pkg::PRIMARY_BUCKETS_DEF,
  parameter int unsigned OVERFLOW_BUCKETS = chi_pkg::OVERFLOW_BUCKETS_DEF,
  parameter int unsigned OFFSET_BITS      = chi_pkg::OFFSET_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [chi_pkg::CMD_W-1:0]    cmd,
  input  logic [chi_pkg::KEY_W-1:0]    hash_key,
  input  logic [chi_pkg::OFF_IN_W-1:0] row_offset,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [chi_pkg::STATUS_W-1:0] status,
  output logic [chi_pkg::OFF_IN_W-1:0] found_offset
);

  chi_pkg::dp_cmd_t    dp_cmd;
  chi_pkg::dp_status_t dp_st;

  chi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_cmd   (cmd),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (dp_cmd),
    .st       (dp_st)
  );

  chi_datapath #(
    .PRIMARY_BUCKETS (PRIMARY_BUCKETS),
    .OVERFLOW_BUCKETS(OVERFLOW_BUCKETS),
    .OFFSET_BITS     (OFFSET_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .hash_key    (hash_key),
    .row_offset  (row_offset),
    .cmd         (dp_cmd),
    .st          (dp_st),
    .status      (status),
    .found_offset(found_offset)
  );

endmodule
